// File: sv/llst_pkg.sv
// Shared types and constants for the least-loaded server tracker.
`default_nettype none
package llst_pkg;

  localparam int MaxServers = 16;
  localparam int MaxObjects = 256;
  localparam int SrvIdxW = $clog2(MaxServers);
  localparam int ObjIdxW = $clog2(MaxObjects);
  localparam int CntW = (ObjIdxW + 1 > SrvIdxW) ? ObjIdxW + 1 : SrvIdxW;
  localparam logic [31:0] MaxU32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OpAddServer    = 3'd0,
    OpRemoveServer = 3'd1,
    OpAddObject    = 3'd2,
    OpRemoveObject = 3'd3,
    OpLookupObject = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StSrvFull = 2'd1,
    StObjFull = 2'd2,
    StMissing = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] server_id;
    logic [63:0] object_id;
  } in_t;

  typedef struct packed {
    logic [63:0] balance_server;
    logic [31:0] balance_count;
    logic [63:0] owner_server;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic               latch;
    logic               srv_scan;
    logic               obj_rd;
    logic               apply;
    logic               min_scan;
    logic               out_load;
    logic [SrvIdxW-1:0] sidx;
    logic [ObjIdxW-1:0] oidx;
  } cmd_t;

  typedef struct packed {
    logic need_obj_scan;
    logic need_rescan;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/llst_ctrl.sv
// Sequencing state machine for the least-loaded server tracker.
`default_nettype none
module llst_ctrl import llst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    Idle  = 6'b000001,
    SScan = 6'b000010,
    OScan = 6'b000100,
    Apply = 6'b001000,
    MScan = 6'b010000,
    Done  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    cmd_o.sidx = cnt_q[SrvIdxW-1:0];
    cmd_o.oidx = cnt_q[ObjIdxW-1:0];
    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          cnt_d = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        cmd_o.srv_scan = 1'b1;
        if (cnt_q == CntW'(MaxServers - 1)) begin
          cnt_d = '0;
          state_d = sts_i.need_obj_scan ? OScan : Apply;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      OScan: begin
        if (cnt_q == CntW'(MaxObjects)) begin
          cnt_d = '0;
          state_d = Apply;
        end else begin
          cmd_o.obj_rd = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      Apply: begin
        cmd_o.apply = 1'b1;
        cnt_d = '0;
        state_d = sts_i.need_rescan ? MScan : Done;
      end
      MScan: begin
        cmd_o.min_scan = 1'b1;
        if (cnt_q == CntW'(MaxServers - 1)) begin
          cnt_d = '0;
          state_d = Done;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      Done: begin
        if (!sts_i.out_full || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  assign in_stall_o = (state_q != Idle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!sts_i.out_full || !out_stall_i))
    else $error("result loaded over a held result");

endmodule
`default_nettype wire

// File: sv/llst_datapath.sv
// Server table, object table, minimum tracking and result register.
`default_nettype none
module llst_datapath import llst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] owner;
  } obj_entry_t;

  logic [2:0]  op_q;
  logic [63:0] sid_q, oid_q;

  logic        srv_valid_q [MaxServers];
  logic [63:0] srv_ident_q [MaxServers];
  logic [31:0] srv_load_q  [MaxServers];

  logic               srv_hit_q, srv_free_q;
  logic [SrvIdxW-1:0] srv_idx_q, srv_fidx_q;
  logic [31:0]        srv_load_hit_q;

  logic       obj_valid_q [MaxObjects];
  obj_entry_t obj_mem     [MaxObjects];
  obj_entry_t rd_q;
  logic               rd_en_q;
  logic [ObjIdxW-1:0] rd_addr_q;

  logic               obj_hit_q, obj_free_q;
  logic [ObjIdxW-1:0] obj_idx_q, obj_fidx_q;
  logic [63:0]        owner_match_q;

  logic [31:0] least_count_q;
  logic [63:0] least_server_q;
  logic [63:0] owner_q;
  logic [1:0]  status_q;
  logic        out_valid_q;
  out_t        out_q;

  logic               srv_wr, srv_wvalid;
  logic [SrvIdxW-1:0] srv_wsel;
  logic [31:0]        srv_wload, load_dec;
  logic               obj_wr, obj_clr;
  logic [ObjIdxW-1:0] obj_wsel;
  logic               least_wr;
  logic [31:0]        least_cnt_new;
  logic [1:0]         status_new;
  logic [63:0]        owner_new;
  logic               rescan;
  logic               rd_entry_valid;
  logic [31:0]        base_cnt;
  logic [63:0]        base_srv;

  assign rd_entry_valid = obj_valid_q[rd_addr_q];
  assign load_dec = (srv_load_hit_q == 32'd0) ? 32'd0 : srv_load_hit_q - 32'd1;

  always_comb begin
    srv_wr = 1'b0;
    srv_wvalid = 1'b1;
    srv_wsel = srv_idx_q;
    srv_wload = srv_load_hit_q;
    obj_wr = 1'b0;
    obj_clr = 1'b0;
    obj_wsel = obj_idx_q;
    least_wr = 1'b0;
    least_cnt_new = 32'd0;
    status_new = StOk;
    owner_new = 64'd0;
    rescan = 1'b0;
    case (op_q)
      OpAddServer: begin
        if (srv_hit_q || srv_free_q) begin
          srv_wr = 1'b1;
          srv_wsel = srv_hit_q ? srv_idx_q : srv_fidx_q;
          srv_wload = 32'd0;
          least_wr = 1'b1;
        end else begin
          status_new = StSrvFull;
        end
      end
      OpRemoveServer: begin
        rescan = 1'b1;
        if (srv_hit_q) begin
          srv_wr = 1'b1;
          srv_wvalid = 1'b0;
        end else begin
          status_new = StMissing;
        end
      end
      OpAddObject: begin
        if (obj_hit_q || obj_free_q) begin
          obj_wr = 1'b1;
          obj_wsel = obj_hit_q ? obj_idx_q : obj_fidx_q;
          if (srv_hit_q) begin
            srv_wr = 1'b1;
            srv_wload = (srv_load_hit_q == MaxU32) ? MaxU32 : srv_load_hit_q + 32'd1;
            rescan = 1'b1;
          end else begin
            status_new = StMissing;
          end
        end else begin
          status_new = StObjFull;
        end
      end
      OpRemoveObject: begin
        obj_clr = obj_hit_q;
        if (srv_hit_q) begin
          srv_wr = 1'b1;
          srv_wload = load_dec;
          if (load_dec < least_count_q) begin
            least_wr = 1'b1;
            least_cnt_new = load_dec;
          end
        end else begin
          status_new = StMissing;
        end
      end
      OpLookupObject: begin
        if (obj_hit_q) owner_new = owner_match_q;
        else status_new = StMissing;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.out_full = out_valid_q;
    sts_o.need_rescan = rescan;
    case (op_q) inside
      OpRemoveServer, OpAddObject, OpRemoveObject, OpLookupObject:
        sts_o.need_obj_scan = 1'b1;
      default: sts_o.need_obj_scan = 1'b0;
    endcase
  end

  assign base_cnt = (cmd_i.sidx == '0) ? MaxU32 : least_count_q;
  assign base_srv = (cmd_i.sidx == '0) ? 64'd0 : least_server_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= in_data_i.operation;
      sid_q <= in_data_i.server_id;
      oid_q <= in_data_i.object_id;
    end
    if (cmd_i.apply && srv_wr) begin
      srv_ident_q[srv_wsel] <= sid_q;
      srv_load_q[srv_wsel] <= srv_wload;
    end
    if (cmd_i.apply && obj_wr) obj_mem[obj_wsel] <= '{key: oid_q, owner: sid_q};
    if (cmd_i.obj_rd) rd_q <= obj_mem[cmd_i.oidx];
    rd_addr_q <= cmd_i.oidx;
    if (cmd_i.srv_scan && srv_valid_q[cmd_i.sidx] && srv_ident_q[cmd_i.sidx] == sid_q
        && !srv_hit_q) begin
      srv_idx_q <= cmd_i.sidx;
      srv_load_hit_q <= srv_load_q[cmd_i.sidx];
    end
    if (cmd_i.srv_scan && !srv_valid_q[cmd_i.sidx] && !srv_free_q) srv_fidx_q <= cmd_i.sidx;
    if (rd_en_q && rd_entry_valid && rd_q.key == oid_q && !obj_hit_q) begin
      obj_idx_q <= rd_addr_q;
      owner_match_q <= rd_q.owner;
    end
    if (rd_en_q && !rd_entry_valid && !obj_free_q) obj_fidx_q <= rd_addr_q;
    if (cmd_i.out_load) begin
      out_q <= '{balance_server: least_server_q, balance_count: least_count_q,
                 owner_server: owner_q, status: status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_hit_q <= 1'b0;
      srv_free_q <= 1'b0;
      obj_hit_q <= 1'b0;
      obj_free_q <= 1'b0;
      rd_en_q <= 1'b0;
      least_count_q <= 32'd0;
      least_server_q <= 64'd0;
      owner_q <= 64'd0;
      status_q <= StOk;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxServers; i++) srv_valid_q[i] <= 1'b0;
    end else begin
      rd_en_q <= cmd_i.obj_rd;
      if (cmd_i.latch) begin
        srv_hit_q <= 1'b0;
        srv_free_q <= 1'b0;
        obj_hit_q <= 1'b0;
        obj_free_q <= 1'b0;
      end else begin
        if (cmd_i.srv_scan && srv_valid_q[cmd_i.sidx] && srv_ident_q[cmd_i.sidx] == sid_q)
          srv_hit_q <= 1'b1;
        if (cmd_i.srv_scan && !srv_valid_q[cmd_i.sidx]) srv_free_q <= 1'b1;
        if (rd_en_q && rd_entry_valid && rd_q.key == oid_q && op_q != OpRemoveServer)
          obj_hit_q <= 1'b1;
        if (rd_en_q && !rd_entry_valid) obj_free_q <= 1'b1;
      end
      if (cmd_i.apply) begin
        if (srv_wr) srv_valid_q[srv_wsel] <= srv_wvalid;
        if (least_wr) begin
          least_count_q <= least_cnt_new;
          least_server_q <= sid_q;
        end
        owner_q <= owner_new;
        status_q <= status_new;
      end
      if (cmd_i.min_scan) begin
        if (srv_valid_q[cmd_i.sidx] && srv_load_q[cmd_i.sidx] < base_cnt) begin
          least_count_q <= srv_load_q[cmd_i.sidx];
          least_server_q <= srv_ident_q[cmd_i.sidx];
        end else begin
          least_count_q <= base_cnt;
          least_server_q <= base_srv;
        end
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxObjects; i++) obj_valid_q[i] <= 1'b0;
    end else begin
      if (rd_en_q && op_q == OpRemoveServer && rd_entry_valid && rd_q.owner == sid_q)
        obj_valid_q[rd_addr_q] <= 1'b0;
      if (cmd_i.apply && obj_wr) obj_valid_q[obj_wsel] <= 1'b1;
      if (cmd_i.apply && obj_clr) obj_valid_q[obj_wsel] <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && srv_hit_q) |-> srv_valid_q[srv_idx_q])
    else $error("matched server slot not valid at apply");

  a_add_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && op_q == OpAddServer && (srv_hit_q || srv_free_q))
      |=> (least_count_q == 32'd0 && least_server_q == $past(sid_q)))
    else $error("add server did not take the minimum");

endmodule
`default_nettype wire

// File: sv/least_loaded_server_tracker.sv
// Top level of the least-loaded server tracker.
// Usage: one command per input transfer (in_valid_i / in_stall_o, payload
// in_data_i: operation, server_id, object_id). Each command yields exactly
// one result transfer (out_valid_o / out_stall_i, payload out_data_o: the
// least-loaded server and its count, the lookup owner and a status).
// The block handles one command at a time; in_stall_o is high while busy.
// Per command: an accept step, a walk of the server table, then for every
// command but add server and the unused codes a walk of the object table
// (one memory read per cycle through its single read port), an apply step,
// a walk for the minimum when the minimum is recomputed, and a load of the
// result register.
// The result register holds the result while out_stall_i is high; the next
// result waits until it is taken.
// Reset empties both tables and clears the minimum to server 0, count 0.
`default_nettype none
module least_loaded_server_tracker import llst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  llst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  llst_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// File: tb/tb_least_loaded_server_tracker.sv
// Testbench for the least-loaded server tracker: directed and random commands vs. a predictor.
`timescale 1ns / 100ps
module tb_least_loaded_server_tracker;
  import llst_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  least_loaded_server_tracker i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bit          srv_used [MaxServers];
  logic [63:0] srv_id [MaxServers];
  logic [31:0] srv_load [MaxServers];
  bit          obj_used [MaxObjects];
  logic [63:0] obj_key [MaxObjects];
  logic [63:0] obj_owner [MaxObjects];
  logic [31:0] min_count;
  logic [63:0] min_server;

  out_t expected_results [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int op_counts [8];

  logic [63:0] id_pool [8];
  logic [63:0] key_pool [24];

  function automatic int server_slot(logic [63:0] id);
    for (int i = 0; i < MaxServers; i++) if (srv_used[i] && srv_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int object_slot(logic [63:0] key);
    for (int i = 0; i < MaxObjects; i++) if (obj_used[i] && obj_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void rescan_least();
    min_count = MaxU32;
    min_server = '0;
    for (int i = 0; i < MaxServers; i++)
      if (srv_used[i] && srv_load[i] < min_count) begin
        min_count = srv_load[i];
        min_server = srv_id[i];
      end
  endfunction

  function automatic out_t predict_balance(in_t cmd);
    out_t r;
    int s;
    int o;
    r = '0;
    r.status = StOk;
    case (cmd.operation)
      OpAddServer: begin
        s = server_slot(cmd.server_id);
        if (s < 0)
          for (int i = 0; i < MaxServers; i++) if (!srv_used[i]) begin s = i; break; end
        if (s < 0) r.status = StSrvFull;
        else begin
          srv_used[s] = 1'b1;
          srv_id[s] = cmd.server_id;
          srv_load[s] = '0;
          min_count = '0;
          min_server = cmd.server_id;
        end
      end
      OpRemoveServer: begin
        s = server_slot(cmd.server_id);
        if (s >= 0) srv_used[s] = 1'b0;
        else r.status = StMissing;
        for (int i = 0; i < MaxObjects; i++)
          if (obj_used[i] && obj_owner[i] == cmd.server_id) obj_used[i] = 1'b0;
        rescan_least();
      end
      OpAddObject: begin
        o = object_slot(cmd.object_id);
        if (o < 0)
          for (int i = 0; i < MaxObjects; i++) if (!obj_used[i]) begin o = i; break; end
        if (o < 0) r.status = StObjFull;
        else begin
          obj_used[o] = 1'b1;
          obj_key[o] = cmd.object_id;
          obj_owner[o] = cmd.server_id;
          s = server_slot(cmd.server_id);
          if (s >= 0) begin
            if (srv_load[s] != MaxU32) srv_load[s]++;
            rescan_least();
          end else r.status = StMissing;
        end
      end
      OpRemoveObject: begin
        o = object_slot(cmd.object_id);
        if (o >= 0) obj_used[o] = 1'b0;
        s = server_slot(cmd.server_id);
        if (s >= 0) begin
          if (srv_load[s] != 0) srv_load[s]--;
          if (srv_load[s] < min_count) begin
            min_count = srv_load[s];
            min_server = cmd.server_id;
          end
        end else r.status = StMissing;
      end
      OpLookupObject: begin
        o = object_slot(cmd.object_id);
        if (o >= 0) r.owner_server = obj_owner[o];
        else r.status = StMissing;
      end
      default: ;
    endcase
    r.balance_server = min_server;
    r.balance_count = min_count;
    return r;
  endfunction

  task automatic send_command(logic [2:0] op, logic [63:0] sid, logic [63:0] oid);
    in_t cmd;
    cmd.operation = op;
    cmd.server_id = sid;
    cmd.object_id = oid;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_balance(cmd));
    op_counts[op]++;
    items_sent++;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %p", out_data_o);
        end else begin
          out_t e;
          e = expected_results.pop_front();
          if (out_data_o.balance_server !== e.balance_server ||
              out_data_o.balance_count !== e.balance_count ||
              out_data_o.owner_server !== e.owner_server ||
              out_data_o.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p, got %p", results_seen, e, out_data_o);
          end
        end
      end
      out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("FAIL least_loaded_server_tracker");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(OpLookupObject, 64'd0, 64'd5);
    send_command(OpRemoveObject, 64'd9, 64'd5);
    send_command(OpAddObject, 64'd9, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(OpAddServer, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_command(OpAddServer, 64'd0, 64'd0);
    send_command(OpAddObject, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
    send_command(OpAddObject, 64'd0, 64'd2);
    send_command(OpAddObject, 64'd0, 64'd1);
    send_command(OpLookupObject, 64'd0, 64'd1);
    send_command(OpLookupObject, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(OpRemoveObject, 64'd0, 64'd2);
    send_command(OpRemoveObject, 64'd0, 64'd2);
    send_command(OpRemoveObject, 64'd0, 64'd2);
    send_command(3'd5, 64'd1, 64'd1);
    send_command(3'd6, 64'd1, 64'd1);
    send_command(3'd7, 64'd1, 64'd1);
    send_command(OpRemoveServer, 64'd9, 64'd0);
    send_command(OpRemoveServer, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_command(OpRemoveServer, 64'd0, 64'd0);
    send_command(OpLookupObject, 64'd0, 64'd2);
  endtask

  task automatic test_full_tables();
    for (int i = 0; i < MaxServers + 2; i++) send_command(OpAddServer, 64'(100 + i), 64'd0);
    send_command(OpAddServer, 64'd105, 64'd0);
    for (int i = 0; i < MaxObjects + 3; i++)
      send_command(OpAddObject, 64'(100 + i % 20), {$urandom(), $urandom()});
    send_command(OpAddObject, 64'd101, obj_key[7]);
    send_command(OpLookupObject, 64'd0, obj_key[200]);
    for (int i = 0; i < MaxServers + 2; i++) send_command(OpRemoveServer, 64'(100 + i), 64'd0);
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) op = 3'($urandom_range(7));
      else if (pick < 22) op = OpAddServer;
      else if (pick < 30) op = OpRemoveServer;
      else if (pick < 62) op = OpAddObject;
      else if (pick < 82) op = OpRemoveObject;
      else op = OpLookupObject;
      if ($urandom_range(19) == 0)
        send_command(op, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      else
        send_command(op, id_pool[$urandom_range(7)], key_pool[$urandom_range(23)]);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) id_pool[i] = {$urandom(), $urandom()};
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom(), $urandom()};
    id_pool[0] = '0;
    id_pool[1] = '1;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < MaxServers; i++) begin
      srv_used[i] = 1'b0; srv_id[i] = '0; srv_load[i] = '0;
    end
    for (int i = 0; i < MaxObjects; i++) begin
      obj_used[i] = 1'b0; obj_key[i] = '0; obj_owner[i] = '0;
    end
    min_count = '0;
    min_server = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_tables();
    test_random(400);
    drain_results();
    send_idle_pct = 47;
    test_random(400);
    send_idle_pct = 0;
    stall_pct = 47;
    test_random(400);
    send_idle_pct = 18;
    stall_pct = 18;
    test_random(300);
    send_idle_pct = 0;
    stall_pct = 0;
    test_random(50);

    drain_results();
    repeat (400) @(posedge clk_i);
    $display("covered %0d commands: add server %0d, remove server %0d, add object %0d,",
             items_sent, op_counts[0], op_counts[1], op_counts[2]);
    $display("  remove object %0d, lookup %0d, unused codes %0d; %0d mismatches",
             op_counts[3], op_counts[4], op_counts[5] + op_counts[6] + op_counts[7], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS least_loaded_server_tracker");
    end else begin
      $display("FAIL least_loaded_server_tracker");
    end
    $finish;
  end

endmodule
